// ===== src/okl_pkg.sv =====
// Package for the ordered key list: widths, operation and status codes, control types.
`timescale 1ns / 1ps
`default_nettype none
package okl_pkg;

    localparam int LIST_DEPTH_DEF = 32;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int TAG_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;

    // Operation codes. Code 3 is unused and is answered as a miss.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    // Conditions seen by the sequencer.
    typedef struct packed {
        logic accept;
        logic start_scan;
        logic hit;
        logic del;
        logic more_scan;
        logic more_shift;
        logic out_free;
    } t_cond;

    // Strobes issued by the sequencer.
    typedef struct packed {
        logic in_ready;
        logic scan;
        logic shift;
        logic finish;
    } t_ctrl;

endpackage
`default_nettype wire

// ===== src/okl_if.sv =====
// Handshake interfaces for the request and response words of the ordered key list.
`timescale 1ns / 1ps
`default_nettype none
interface okl_req_if
    import okl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] payload_tag;

    modport source (output valid, output operation, output key, output payload_tag,
                    input ready);
    modport sink   (input valid, input operation, input key, input payload_tag,
                    output ready);
endinterface

interface okl_rsp_if
    import okl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface
`default_nettype wire

// ===== src/okl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module okl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/okl_fsm.sv =====
// Sequencer that steps one operation through scan, shift and finish.
`timescale 1ns / 1ps
`default_nettype none
module okl_fsm
    import okl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cond i_cond,
    output t_ctrl      o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cond.accept) begin
                    n_state = i_cond.start_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                priority if (i_cond.hit) begin
                    n_state = (i_cond.del && i_cond.more_scan) ? S_SHIFT : S_FINISH;
                end else if (i_cond.more_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                n_state = i_cond.more_shift ? S_SHIFT : S_FINISH;
            end
            S_FINISH: begin
                if (i_cond.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.in_ready = (r_state == S_IDLE);
        o_ctrl.scan     = (r_state == S_SCAN);
        o_ctrl.shift    = (r_state == S_SHIFT);
        o_ctrl.finish   = (r_state == S_FINISH) && i_cond.out_free;
    end

endmodule
`default_nettype wire

// ===== src/ordered_key_list.sv =====
// Top level of the ordered key list: entry RAM, shared compare and index unit, result register.
//
//  Channel  | Dir | Fields                               | Handshake
//  ---------+-----+--------------------------------------+------------------
//  i_req    | in  | operation, key, payload_tag          | valid / ready
//  o_rsp    | out | status, position, entry_count        | valid / ready
//
// A search or delete walks the entries from the head through the single RAM read port, one
// per cycle, and a delete then moves each later entry up one slot, one per cycle. A word is
// taken only while the sequencer is idle, and a finished result may wait in the output
// register meanwhile. Reset empties the list at once; a stalled output holds the sequencer
// in its finish step.
`timescale 1ns / 1ps
`default_nettype none
module ordered_key_list
    import okl_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    okl_req_if.sink    i_req,
    okl_rsp_if.source  o_rsp
);

    localparam int IW     = $clog2(LIST_DEPTH);
    localparam int CW     = $clog2(LIST_DEPTH + 1);
    localparam int CXW    = CW + 1;
    localparam int DW     = KEY_W + TAG_W;
    localparam int POS_MX = (1 << POS_W) - 1;
    localparam int CNT_MX = (1 << CNT_W) - 1;

    t_cond cond;
    t_ctrl ctrl;

    // Operation held for the duration of a scan or shift.
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [ST_W-1:0]  r_status;
    logic [IW-1:0]    r_pos;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_count;

    logic [ST_W-1:0]  r_out_status;
    logic [POS_W-1:0] r_out_pos;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_valid;

    logic             accept;
    logic             is_insert;
    logic             not_full;
    logic             key_match;
    logic [CXW-1:0]   idx_p1;
    logic [CXW-1:0]   idx_p2;
    logic [CW-1:0]    fin_count;
    logic [31:0]      pos_ext;
    logic [31:0]      cnt_ext;

    logic             ram_we;
    logic [IW-1:0]    ram_wa;
    logic [DW-1:0]    ram_wd;
    logic [IW-1:0]    ram_ra;
    logic [DW-1:0]    ram_rd;

    assign accept    = i_req.valid && ctrl.in_ready;
    assign is_insert = (i_req.operation == OP_INSERT);
    assign not_full  = (r_count < CW'(LIST_DEPTH));

    // The shared unit: one key compare and the index arithmetic around it.
    assign key_match = (ram_rd[KEY_W-1:0] == r_key);
    assign idx_p1    = CXW'(r_idx) + CXW'(1);
    assign idx_p2    = CXW'(r_idx) + CXW'(2);

    assign cond.accept     = accept;
    assign cond.start_scan = ((i_req.operation == OP_SEARCH) ||
                              (i_req.operation == OP_DELETE)) && (r_count != '0);
    assign cond.hit        = key_match;
    assign cond.del        = (r_op == OP_DELETE);
    assign cond.more_scan  = (idx_p1 < CXW'(r_count));
    assign cond.more_shift = (idx_p2 < CXW'(r_count));
    assign cond.out_free   = !r_out_valid || o_rsp.ready;

    okl_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    // Write port: append on insert, move an entry up one slot while shifting.
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_idx;
        ram_wd = ram_rd;
        if (accept && is_insert && not_full) begin
            ram_we = 1'b1;
            ram_wa = r_count[IW-1:0];
            ram_wd = {i_req.payload_tag, i_req.key};
        end else if (ctrl.shift) begin
            ram_we = 1'b1;
        end
    end

    // Read port runs one entry ahead of the compare, two ahead of the shift write.
    always_comb begin
        priority if (ctrl.scan) begin
            ram_ra = idx_p1[IW-1:0];
        end else if (ctrl.shift) begin
            ram_ra = idx_p2[IW-1:0];
        end else begin
            ram_ra = '0;
        end
    end

    okl_ram #(
        .WIDTH (DW),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // A successful delete gives up the tail slot when its result is posted.
    assign fin_count = ((r_op == OP_DELETE) && (r_status == ST_DONE)) ?
                       r_count - CW'(1) : r_count;
    assign pos_ext   = 32'(r_pos);
    assign cnt_ext   = 32'(fin_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && is_insert && not_full) begin
                r_count <= r_count + CW'(1);
            end else if (ctrl.finish) begin
                r_count <= fin_count;
            end
            if (ctrl.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
            r_pos <= '0;
            r_idx <= '0;
            if (is_insert) begin
                r_status <= not_full ? ST_DONE : ST_FULL;
            end else begin
                r_status <= ST_MISSING;
            end
        end else if (ctrl.scan) begin
            if (key_match) begin
                r_status <= ST_DONE;
                if (r_op == OP_SEARCH) begin
                    r_pos <= r_idx;
                end
            end else if (cond.more_scan) begin
                r_idx <= idx_p1[IW-1:0];
            end
        end else if (ctrl.shift && cond.more_shift) begin
            r_idx <= idx_p1[IW-1:0];
        end
    end

    // Output register; position and count saturate at their field limits.
    always_ff @(posedge i_clk) begin
        if (ctrl.finish) begin
            r_out_status <= r_status;
            r_out_pos    <= (pos_ext > 32'(POS_MX)) ? POS_W'(POS_MX) : pos_ext[POS_W-1:0];
            r_out_count  <= (cnt_ext > 32'(CNT_MX)) ? CNT_W'(CNT_MX) : cnt_ext[CNT_W-1:0];
        end
    end

    assign i_req.ready       = ctrl.in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.entry_count = r_out_count;

endmodule
`default_nettype wire

// ===== dv/ordered_key_list_tb.sv =====
// Testbench for the ordered key list: directed and random operations checked word by word.
`timescale 1ns / 1ps
module ordered_key_list_tb;
    import okl_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int QUIET_LIMIT = 3000;  // cycles with no accepted word before giving up
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the stall test
    localparam int RANDOM_OPS  = 1870;

    // The one operation code that has no meaning; the block answers it as a miss.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } t_rsp_word;

    logic i_clk   = 1'b0;
    logic i_rst_n;

    okl_req_if req_if ();
    okl_rsp_if rsp_if ();

    ordered_key_list #(
        .LIST_DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the list contents, head first, and the response words still owed.
    logic [KEY_W-1:0] held_keys[$];
    logic [TAG_W-1:0] held_tags[$];
    t_rsp_word        rsp_due[$];

    int n_errors      = 0;
    bit idle_en       = 1'b1;
    int rsp_hold_req  = 0;
    int insert_weight = 50;

    // Index of the first entry with a matching key, or -1 when there is none.
    function automatic int find_key(logic [KEY_W-1:0] key);
        foreach (held_keys[i]) begin
            if (held_keys[i] == key) return i;
        end
        return -1;
    endfunction

    // Applies one operation to the mirrored list and returns the response it must give.
    function automatic t_rsp_word apply_list_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                logic [TAG_W-1:0] tag);
        t_rsp_word r;
        int        hit;
        r.status   = ST_MISSING;
        r.position = '0;
        case (op)
            OP_INSERT: begin
                if (held_keys.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_keys.push_back(key);
                    held_tags.push_back(tag);
                    r.status = ST_DONE;
                end
            end
            OP_SEARCH: begin
                hit = find_key(key);
                if (hit >= 0) begin
                    r.status   = ST_DONE;
                    r.position = (hit > 31) ? 5'd31 : hit[POS_W-1:0];
                end
            end
            OP_DELETE: begin
                hit = find_key(key);
                if (hit >= 0) begin
                    held_keys.delete(hit);
                    held_tags.delete(hit);
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        r.entry_count = (held_keys.size() > 63) ? 6'd63 : CNT_W'(held_keys.size());
        return r;
    endfunction

    // Idle length for either side: mostly none, sometimes a few cycles, rarely a long gap.
    function automatic int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Keys lean toward ones already held so that searches and deletes hit often.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (held_keys.size() != 0 && r < 65) begin
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        end
        if (r < 85) return $urandom_range(0, 7);
        if (r < 88) return '1;
        return $urandom();
    endfunction

    // Offers one request word and returns at the edge where it is taken. The valid
    // stays high afterwards so that back-to-back words leave no bubble.
    task automatic issue_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.key         <= key;
        req_if.payload_tag <= tag;
        do @(posedge i_clk); while (!req_if.ready);
        rsp_due.push_back(apply_list_op(op, key, tag));
    endtask

    task automatic idle_req();
        req_if.valid <= 1'b0;
    endtask

    task automatic issue_random_op();
        int               r;
        logic [OP_W-1:0]  op;
        r = $urandom_range(0, 99);
        if (r < insert_weight) op = OP_INSERT;
        else if (r >= 97) op = OP_UNUSED;
        else if (r[0]) op = OP_SEARCH;
        else op = OP_DELETE;
        issue_op(op, pick_key(), $urandom());
    endtask

    // Operations on a freshly reset, empty list.
    task automatic test_empty_list();
        issue_op(OP_SEARCH, 32'd0, 32'd0);
        issue_op(OP_DELETE, '1, 32'd0);
        issue_op(OP_UNUSED, 32'd0, '1);
    endtask

    // Every operation with extreme keys and tags, duplicates, and head and middle removal.
    task automatic test_basic_ops();
        issue_op(OP_INSERT, 32'd0, 32'd0);
        issue_op(OP_INSERT, '1, '1);
        issue_op(OP_INSERT, 32'd0, 32'h5A5A_A5A5);
        issue_op(OP_INSERT, 32'h8000_0001, 32'h0123_4567);
        issue_op(OP_SEARCH, 32'd0, 32'd0);
        issue_op(OP_SEARCH, '1, 32'd0);
        issue_op(OP_SEARCH, 32'h0000_1234, 32'd0);
        issue_op(OP_DELETE, 32'd0, 32'd0);
        issue_op(OP_SEARCH, 32'd0, 32'd0);
        issue_op(OP_DELETE, 32'h7FFF_FFFE, 32'd0);
        issue_op(OP_UNUSED, '1, '1);
        issue_op(OP_DELETE, 32'd0, 32'd0);
        issue_op(OP_SEARCH, 32'h8000_0001, 32'd0);
        issue_op(OP_DELETE, 32'h8000_0001, 32'd0);
        issue_op(OP_DELETE, '1, 32'd0);
        issue_op(OP_SEARCH, '1, 32'd0);
    endtask

    // Fills the list, pushes inserts against a full list, then works on both ends.
    task automatic test_full_list();
        while (held_keys.size() < DEPTH) issue_op(OP_INSERT, $urandom(), $urandom());
        issue_op(OP_INSERT, '1, '1);
        issue_op(OP_INSERT, 32'd0, 32'd0);
        issue_op(OP_SEARCH, held_keys[DEPTH-1], 32'd0);
        issue_op(OP_DELETE, held_keys[DEPTH-1], 32'd0);
        issue_op(OP_INSERT, 32'hFFFF_0000, 32'h0000_FFFF);
        issue_op(OP_DELETE, held_keys[0], 32'd0);
        issue_op(OP_SEARCH, 32'hFFFF_0000, 32'd0);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // result register fills and the request side has to stall.
    task automatic test_output_stall();
        idle_en      = 1'b0;
        rsp_hold_req = HOLD_CYCLES;
        repeat (10) issue_random_op();
        idle_en      = 1'b1;
    endtask

    // The sender stops until every owed response has come back, then resumes.
    task automatic test_drain_pause();
        repeat (6) issue_random_op();
        idle_req();
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (6) issue_random_op();
    endtask

    // Long random run. The insert share changes every hundred words so the list
    // wanders between empty and full; some stretches run with no idling at all.
    task automatic test_random_ops();
        int sel;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 100 == 0) begin
                idle_en = ($urandom_range(0, 3) != 0);
                sel     = $urandom_range(0, 2);
                insert_weight = (sel == 0) ? 70 : (sel == 1) ? 45 : 25;
            end
            issue_random_op();
        end
        idle_en = 1'b1;
    endtask

    // Response side: checks each accepted word against the oldest owed one and
    // drives ready with random stalls or a requested long hold-off.
    initial begin : rsp_side
        int        stall_left;
        int        hold_left;
        t_rsp_word want;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (rsp_due.size() == 0) begin
                    $display("%0t: response word with none owed: status %0d position %0d %s",
                             $time, rsp_if.status, rsp_if.position,
                             $sformatf("count %0d", rsp_if.entry_count));
                    n_errors++;
                end else begin
                    want = rsp_due.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp_if.status);
                        n_errors++;
                    end
                    if (rsp_if.position !== want.position) begin
                        $display("%0t: position mismatch, expected %0d, got %0d",
                                 $time, want.position, rsp_if.position);
                        n_errors++;
                    end
                    if (rsp_if.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count mismatch, expected %0d, got %0d",
                                 $time, want.entry_count, rsp_if.entry_count);
                        n_errors++;
                    end
                end
            end
            if (rsp_hold_req > 0) begin
                hold_left    = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                rsp_if.ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Ends the run if no word moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_INSERT;
        req_if.key         <= '0;
        req_if.payload_tag <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_output_stall();
        test_drain_pause();
        test_random_ops();

        // Let every owed response arrive, then watch a while for stray words.
        idle_req();
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/okl_pkg.sv
src/okl_if.sv
src/okl_ram.sv
src/okl_fsm.sv
src/ordered_key_list.sv
dv/ordered_key_list_tb.sv
